### rtl/mri_pkg.sv
// Shared types and constants for the MLP inference core.
package mri_pkg;

    localparam int unsigned MAX_LAYERS_DEF   = 4;
    localparam int unsigned MAX_WIDTH_DEF    = 64;
    localparam int unsigned WEIGHT_DEPTH_DEF = 16384;
    localparam int unsigned BIAS_DEPTH_DEF   = 256;
    localparam int unsigned FRAC_BITS_DEF    = 8;

    // Most results one pass may give.
    localparam int unsigned RESULT_CAP = 64;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned ADDR_W  = 14;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned ACT_W   = 15;
    localparam int unsigned CFGI_W  = 3;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
    localparam logic [OP_W-1:0] OP_INPUT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] REG_LAYERS = 3'd0;
    localparam logic [CFGI_W-1:0] REG_W_IN   = 3'd1;
    localparam logic [CFGI_W-1:0] REG_W_ONE  = 3'd2;
    localparam logic [CFGI_W-1:0] REG_W_TWO  = 3'd3;
    localparam logic [CFGI_W-1:0] REG_W_THR  = 3'd4;

    // Classified command handed from the front part to the back part.
    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_INPUT  = 2'd2,
        CMD_START  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [VAL_W-1:0]   value;
        logic               in_range;
    } cmd_t;

endpackage

### rtl/mri_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mri_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/mri_front.sv
// Front part: accepts input items, classifies them and queues commands.
module mri_front
    import mri_pkg::*;
#(
    parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int unsigned WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int unsigned BIAS_DEPTH   = BIAS_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [ADDR_W-1:0] in_addr,
    input  logic [VAL_W-1:0]  in_value,
    input  logic              in_last,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;
    // A start command also stores its element; this flag holds input off until it is popped.
    logic              hold_start_reg;
    cmd_t              cls;
    logic              cls_valid;

    // Classify one input item.
    always_comb begin
        cls       = '0;
        cls.addr  = in_addr;
        cls.value = in_value;
        cls_valid = 1'b1;
        case (in_op)
            OP_WEIGHT: begin
                cls.kind     = CMD_WEIGHT;
                cls.in_range = 32'(in_addr) < WEIGHT_DEPTH;
            end
            OP_BIAS: begin
                cls.kind     = CMD_BIAS;
                cls.in_range = 32'(in_addr) < BIAS_DEPTH;
            end
            OP_INPUT: begin
                cls.kind     = in_last ? CMD_START : CMD_INPUT;
                cls.in_range = 32'(in_addr) < MAX_WIDTH;
            end
            default: begin
                cls.kind  = CMD_WEIGHT;
                cls_valid = 1'b0;
            end
        endcase
    end

    assign in_ready  = (count_reg < (QPTR_W+1)'(QDEPTH)) && !hold_start_reg;
    assign push      = in_valid && in_ready && cls_valid;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers; input stalls after a start until the back part takes it from the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            hold_start_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
            if (push && cls.kind == CMD_START) begin
                hold_start_reg <= 1'b1;
            end else if (pop && cmd.kind == CMD_START) begin
                hold_start_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < (QPTR_W+1)'(QDEPTH) || pop))
        else $error("command queue overflow");
    a_count_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance");
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_start_reg |-> !in_ready)
        else $error("input accepted during a pass");
`endif

endmodule

### rtl/mri_back.sv
// Back part: stores loads and runs the forward pass on a shared MAC.
module mri_back
    import mri_pkg::*;
#(
    parameter int unsigned MAX_LAYERS   = MAX_LAYERS_DEF,
    parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int unsigned WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int unsigned BIAS_DEPTH   = BIAS_DEPTH_DEF,
    parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    input  logic [CFG_W-1:0]  cfg_layers,
    input  logic [CFG_W-1:0]  cfg_w0,
    input  logic [CFG_W-1:0]  cfg_w1,
    input  logic [CFG_W-1:0]  cfg_w2,
    input  logic [CFG_W-1:0]  cfg_w3,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [ACT_W-1:0]  res_act,
    output logic [IDX_W-1:0]  res_idx,
    output logic              res_last
);

    localparam int unsigned WA_W  = $clog2(WEIGHT_DEPTH);
    localparam int unsigned BA_W  = $clog2(BIAS_DEPTH);
    localparam int unsigned AA_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned AD    = (MAX_WIDTH > 1) ? MAX_WIDTH : 2;
    localparam int unsigned CAPW  = (MAX_WIDTH < RESULT_CAP) ? MAX_WIDTH : RESULT_CAP;
    localparam int unsigned LCAP  = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int unsigned FA_W  = 24;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ISSUE = 7'b0000010,
        ST_WAIT  = 7'b0000100,
        ST_MAC   = 7'b0001000,
        ST_BIAS  = 7'b0010000,
        ST_WB    = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t             state_reg;
    logic [2:0]         layer_reg;
    logic [2:0]         nl;
    logic [CFG_W-1:0]   cols, rows, outw;
    logic [CFG_W-1:0]   j_reg, n_reg;
    logic [FA_W-1:0]    wrow_reg, wbase_reg, bbase_reg;
    logic               src_pong_reg;
    logic               pipe_v_reg, mul_v_reg, last_j_reg, pipe_last_reg;
    logic               w_ok_reg, b_ok_reg, mul_last_reg;
    logic signed [31:0] acc_reg, prod_reg;
    logic [VAL_W-1:0]   w_rd, b_rd, ping_rd, pong_rd;
    logic [FA_W-1:0]    waddr_full;
    logic [FA_W-1:0]    baddr_full;
    logic [15:0]        fin;
    logic               out_v_reg;
    logic [ACT_W-1:0]   out_act_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_last_reg;

    function automatic logic [CFG_W-1:0] clampw(input logic [CFG_W-1:0] w);
        if (w == '0) return CFG_W'(1);
        if (32'(w) > CAPW) return CFG_W'(CAPW);
        return w;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'(SMAX)) return SMAX;
        if (s < 33'(SMIN)) return SMIN;
        return s[31:0];
    endfunction

    logic [CFG_W-1:0] w0c, w1c, w2c, w3c;
    assign w0c = clampw(cfg_w0);
    assign w1c = clampw(cfg_w1);
    assign w2c = clampw(cfg_w2);
    assign w3c = clampw(cfg_w3);

    // Used layer count and shapes of the current layer.
    always_comb begin
        nl = cfg_layers[2:0];
        if (nl < 3'd2) nl = 3'd2;
        if (32'(nl) > LCAP) nl = 3'(LCAP);
        case (layer_reg)
            3'd1: begin cols = w0c; rows = w1c; end
            3'd2: begin cols = w1c; rows = w2c; end
            default: begin cols = w2c; rows = w3c; end
        endcase
        case (nl)
            3'd2: outw = w1c;
            3'd3: outw = w2c;
            default: outw = w3c;
        endcase
    end

    logic pass_mode;
    assign pass_mode = (state_reg != ST_IDLE);
    assign cmd_ready = !pass_mode;

    logic load_fire;
    assign load_fire = cmd_valid && cmd_ready;

    assign waddr_full = wrow_reg + FA_W'(j_reg);
    assign baddr_full = bbase_reg + FA_W'(n_reg);

    // Memories: weights, biases and the two activation buffers.
    logic                 w_we, b_we, ping_we, pong_we;
    logic [AA_W-1:0]      act_rd_addr, ping_wa, pong_wa;
    logic [VAL_W-1:0]     ping_wd;

    assign w_we = load_fire && cmd.kind == CMD_WEIGHT && cmd.in_range;
    assign b_we = load_fire && cmd.kind == CMD_BIAS && cmd.in_range;
    assign ping_we = (load_fire && (cmd.kind == CMD_INPUT || cmd.kind == CMD_START)
                      && cmd.in_range) || (state_reg == ST_WB && src_pong_reg);
    assign pong_we = (state_reg == ST_WB) && !src_pong_reg;
    assign ping_wa = pass_mode ? AA_W'(n_reg) : AA_W'(cmd.addr);
    assign ping_wd = pass_mode ? fin : cmd.value;
    assign pong_wa = AA_W'(n_reg);
    assign act_rd_addr = (state_reg == ST_WAIT || state_reg == ST_EMIT) ?
                         AA_W'(n_reg) : AA_W'(j_reg);

    mri_ram #(.WIDTH(VAL_W), .DEPTH(WEIGHT_DEPTH)) u_wram (
        .aclk(aclk), .wr_en(w_we), .wr_addr(cmd.addr[WA_W-1:0]), .wr_data(cmd.value),
        .rd_addr(waddr_full[WA_W-1:0]), .rd_data(w_rd));
    mri_ram #(.WIDTH(VAL_W), .DEPTH(BIAS_DEPTH)) u_bram (
        .aclk(aclk), .wr_en(b_we), .wr_addr(cmd.addr[BA_W-1:0]), .wr_data(cmd.value),
        .rd_addr(baddr_full[BA_W-1:0]), .rd_data(b_rd));
    mri_ram #(.WIDTH(VAL_W), .DEPTH(AD)) u_ping (
        .aclk(aclk), .wr_en(ping_we), .wr_addr(ping_wa), .wr_data(ping_wd),
        .rd_addr(act_rd_addr), .rd_data(ping_rd));
    mri_ram #(.WIDTH(VAL_W), .DEPTH(AD)) u_pong (
        .aclk(aclk), .wr_en(pong_we), .wr_addr(pong_wa), .wr_data(fin),
        .rd_addr(act_rd_addr), .rd_data(pong_rd));

    logic signed [VAL_W-1:0] a_op, w_op;
    assign a_op = src_pong_reg ? pong_rd : ping_rd;
    assign w_op = w_ok_reg ? w_rd : '0;

    // Floor shift, saturation and ReLU of the finished sum.
    always_comb begin
        logic signed [31:0] q;
        q = acc_reg >>> FRAC_BITS;
        if (q < 0) fin = '0;
        else if (q > 32'sd32767) fin = 16'h7FFF;
        else fin = q[15:0];
    end

    logic signed [31:0] bias_sh;
    assign bias_sh = (b_ok_reg ? 32'(signed'(b_rd)) : 32'sd0) <<< FRAC_BITS;

    logic out_free;
    assign out_free = !out_v_reg || res_ready;

    // Sequencer: one multiply-accumulate per cycle over each weight row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pipe_v_reg   <= 1'b0;
            mul_v_reg    <= 1'b0;
            out_v_reg    <= 1'b0;
            layer_reg    <= 3'd1;
            src_pong_reg <= 1'b0;
        end else begin
            // Result register: loaded in emit, freed by a result transfer.
            if (state_reg == ST_EMIT && out_free) begin
                out_v_reg <= 1'b1;
            end else if (res_ready) begin
                out_v_reg <= 1'b0;
            end
            // Read stage feeds multiply stage feeds accumulate.
            mul_v_reg <= pipe_v_reg;
            mul_last_reg <= pipe_last_reg;
            if (pipe_v_reg) prod_reg <= 32'(a_op) * 32'(w_op);
            if (mul_v_reg) acc_reg <= sat_add(acc_reg, prod_reg);
            pipe_v_reg <= (state_reg == ST_ISSUE);
            case (state_reg)
                ST_IDLE: begin
                    if (load_fire && cmd.kind == CMD_START) begin
                        state_reg    <= ST_ISSUE;
                        layer_reg    <= 3'd1;
                        src_pong_reg <= 1'b0;
                        wbase_reg    <= '0;
                        wrow_reg     <= '0;
                        bbase_reg    <= '0;
                        n_reg        <= '0;
                        j_reg        <= '0;
                        acc_reg      <= '0;
                    end
                end
                ST_ISSUE: begin
                    pipe_last_reg <= (j_reg + 1'b1 == cols);
                    w_ok_reg      <= 32'(waddr_full) < WEIGHT_DEPTH;
                    b_ok_reg      <= 32'(baddr_full) < BIAS_DEPTH;
                    if (j_reg + 1'b1 == cols) begin
                        state_reg <= ST_MAC;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_MAC: begin
                    if (mul_v_reg && mul_last_reg) state_reg <= ST_BIAS;
                end
                ST_BIAS: begin
                    acc_reg   <= sat_add(acc_reg, bias_sh);
                    state_reg <= ST_WB;
                end
                ST_WB: begin
                    acc_reg <= '0;
                    j_reg   <= '0;
                    if (n_reg + 1'b1 == rows) begin
                        n_reg        <= '0;
                        wbase_reg    <= wbase_reg + FA_W'(rows) * FA_W'(cols);
                        wrow_reg     <= wbase_reg + FA_W'(rows) * FA_W'(cols);
                        bbase_reg    <= bbase_reg + FA_W'(rows);
                        src_pong_reg <= !src_pong_reg;
                        if (layer_reg + 1'b1 == nl) begin
                            state_reg <= ST_WAIT;
                        end else begin
                            layer_reg <= layer_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end else begin
                        n_reg     <= n_reg + 1'b1;
                        wrow_reg  <= wrow_reg + FA_W'(cols);
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_WAIT: begin
                    // Read address is n_reg; data arrives next cycle.
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_act_reg  <= ACT_W'(src_pong_reg ? pong_rd : ping_rd);
                        out_idx_reg  <= IDX_W'(n_reg);
                        out_last_reg <= (n_reg + 1'b1 == outw);
                        if (n_reg + 1'b1 == outw) begin
                            state_reg <= ST_IDLE;
                            n_reg     <= '0;
                        end else begin
                            n_reg     <= n_reg + 1'b1;
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // In the pass, activation reads follow j; in wait and emit they follow n.
    assign res_valid = out_v_reg;
    assign res_act   = out_act_reg;
    assign res_idx   = out_idx_reg;
    assign res_last  = out_last_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_no_cmd_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd_ready)
        else $error("command taken during a pass");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !res_ready) |=> (out_v_reg && $stable(out_idx_reg)))
        else $error("stalled result changed");
`endif

endmodule

### rtl/mlp_relu_inference_core.sv
// Top level of the MLP forward-pass inference core.
//
// Channel   Direction  Accepted when           Contents
// s_axis    in         s_tvalid && s_tready   operation, address, value, last
// m_axis    out        m_tvalid && m_tready   activation, neuron_index, last_output
// cfg       in         cfg_valid && cfg_ready register index, write data
//
// Loads pass through a four-entry command queue.
// Per neuron, a pass issues one MAC per cycle on the weight RAM port, drains the
// read and multiply stages, then bias and write-back; each result is sent from emit.
// Input is held off after a last element until the back part takes it; later
// items wait in the queue while the pass runs.
// aresetn is synchronous, active low; stores are not cleared.
module mlp_relu_inference_core
    import mri_pkg::*;
#(
    parameter int unsigned MAX_LAYERS   = MAX_LAYERS_DEF,
    parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int unsigned WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int unsigned BIAS_DEPTH   = BIAS_DEPTH_DEF,
    parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // tdata: address[13:0], value[29:14], zero fill [31:30]
    input  logic [31:0]       s_tdata,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]   s_tuser,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // tdata: activation[14:0], neuron_index[20:15], zero fill [23:21]
    output logic [23:0]       m_tdata,
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0] layers_reg, w0_reg, w1_reg, w2_reg, w3_reg;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layers_reg <= CFG_W'(2);
            w0_reg     <= CFG_W'(1);
            w1_reg     <= CFG_W'(1);
            w2_reg     <= CFG_W'(1);
            w3_reg     <= CFG_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LAYERS: layers_reg <= {4'd0, cfg_data[2:0]};
                REG_W_IN:   w0_reg <= cfg_data;
                REG_W_ONE:  w1_reg <= cfg_data;
                REG_W_TWO:  w2_reg <= cfg_data;
                REG_W_THR:  w3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    mri_front #(.MAX_WIDTH(MAX_WIDTH), .WEIGHT_DEPTH(WEIGHT_DEPTH),
                .BIAS_DEPTH(BIAS_DEPTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
        .in_addr(s_tdata[13:0]), .in_value(s_tdata[29:14]), .in_last(s_tlast),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

    mri_back #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH),
               .WEIGHT_DEPTH(WEIGHT_DEPTH), .BIAS_DEPTH(BIAS_DEPTH),
               .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .cfg_layers(layers_reg), .cfg_w0(w0_reg), .cfg_w1(w1_reg),
        .cfg_w2(w2_reg), .cfg_w3(w3_reg),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_act(act), .res_idx(idx), .res_last(m_tlast));

    assign m_tdata = {3'b000, idx, act};

endmodule
